// ===== design/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

  // one row of the block table
  typedef struct packed {
    logic [23:0] offset;
    logic [23:0] size;
    logic        is_free;
  } ffha_entry_t;

  // per-operation setup handed from the sequencer to the head cell
  typedef struct packed {
    logic        alloc_en;
    logic        release_en;
    logic        init_en;
    logic        can_split;
    logic [24:0] need;
    logic [25:0] need_hdr;
    logic [26:0] need_split;
    logic [31:0] base_hdr;
    logic [31:0] want;
    logic [23:0] init_size;
  } ffha_ctl_t;

  // what the head cell found during a pass
  typedef struct packed {
    logic        found;
    logic        full;
    logic [31:0] addr;
  } ffha_hres_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_RUN,
    ST_HOLD
  } ffha_state_t;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NO_FIT     = 3'd1;
  localparam logic [2:0] STS_NULL       = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
  localparam logic [2:0] STS_NO_HEAP    = 3'd4;
  localparam logic [2:0] STS_TABLE_FULL = 3'd5;

  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_HEAP_LENGTH = 1'b1;

  // cycles between reading a row at the head and writing its result at the tail
  localparam int unsigned LAG = 3;

endpackage

// ===== design/ffha_cell.sv =====
`timescale 1ns / 1ps

module ffha_cell (
  input  logic                clk,
  input  logic                shift,
  input  ffha_pkg::ffha_entry_t d,
  output ffha_pkg::ffha_entry_t q
);

  ffha_pkg::ffha_entry_t row_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      row_r <= d;
    end
  end

  assign q = row_r;

endmodule

// ===== design/ffha_head.sv =====
`timescale 1ns / 1ps

module ffha_head #(
  parameter int unsigned HDR_BYTES = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  step,
  input  logic                  first,
  input  logic                  in_v,
  input  logic                  emit_en,
  input  ffha_pkg::ffha_entry_t in_entry,
  input  ffha_pkg::ffha_ctl_t   ctl,
  output logic                  out_v,
  output ffha_pkg::ffha_entry_t out_entry,
  output ffha_pkg::ffha_hres_t  res
);

  localparam int unsigned QD = 4;
  localparam int unsigned QW = $clog2(QD);

  ffha_pkg::ffha_entry_t q_r [QD];
  ffha_pkg::ffha_entry_t q_nxt [QD];
  logic [QW:0]           qcnt_r, qcnt_nxt;
  ffha_pkg::ffha_entry_t acc_r, acc_nxt;
  logic                  acc_v_r, acc_v_nxt;
  ffha_pkg::ffha_hres_t  res_r, res_nxt;

  logic                  pop, take_acc;
  logic                  n1_v, n2_v;
  ffha_pkg::ffha_entry_t n1, n2;

  always_comb begin
    pop      = emit_en && (qcnt_r != '0);
    take_acc = emit_en && (qcnt_r == '0) && acc_v_r;
    out_v    = pop || take_acc;
    out_entry = pop ? q_r[0] : acc_r;

    // rows produced by this step
    n1_v    = 1'b0;
    n2_v    = 1'b0;
    n1      = in_entry;
    n2      = in_entry;
    res_nxt = res_r;
    if (step) begin
      if (first && ctl.init_en) begin
        n1_v         = 1'b1;
        n1.offset    = '0;
        n1.size      = ctl.init_size;
        n1.is_free   = 1'b1;
      end else if (in_v) begin
        n1_v = 1'b1;
        if (ctl.alloc_en && !res_r.found && in_entry.is_free &&
            ({1'b0, in_entry.size} >= ctl.need)) begin
          res_nxt.found = 1'b1;
          res_nxt.addr  = ctl.base_hdr + 32'(in_entry.offset);
          n1.is_free    = 1'b0;
          if ({3'b000, in_entry.size} >= ctl.need_split) begin
            if (ctl.can_split) begin
              n1.size    = ctl.need[23:0];
              n2_v       = 1'b1;
              n2.offset  = in_entry.offset + ctl.need_hdr[23:0];
              n2.size    = in_entry.size - ctl.need_hdr[23:0];
              n2.is_free = 1'b1;
            end else begin
              res_nxt.full = 1'b1;
            end
          end
        end else if (ctl.release_en && !res_r.found &&
                     (ctl.want == 32'(in_entry.offset))) begin
          res_nxt.found = 1'b1;
          n1.is_free    = 1'b1;
        end
      end
    end

    // small queue behind an accumulator that merges free neighbours
    q_nxt     = q_r;
    qcnt_nxt  = qcnt_r;
    acc_nxt   = acc_r;
    acc_v_nxt = acc_v_r && !take_acc;
    if (pop) begin
      for (int i = 0; i < QD - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      qcnt_nxt = qcnt_r - 1'b1;
    end
    if (n1_v) begin
      if (acc_v_nxt && acc_nxt.is_free && n1.is_free) begin
        acc_nxt.size = acc_nxt.size + 24'(HDR_BYTES) + n1.size;
      end else begin
        if (acc_v_nxt) begin
          q_nxt[qcnt_nxt[QW-1:0]] = acc_nxt;
          qcnt_nxt = qcnt_nxt + 1'b1;
        end
        acc_nxt   = n1;
        acc_v_nxt = 1'b1;
      end
    end
    if (n2_v) begin
      q_nxt[qcnt_nxt[QW-1:0]] = acc_nxt;
      qcnt_nxt = qcnt_nxt + 1'b1;
      acc_nxt  = n2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r  <= '0;
      acc_v_r <= 1'b0;
      res_r   <= '0;
    end else if (clr) begin
      qcnt_r  <= '0;
      acc_v_r <= 1'b0;
      res_r   <= '0;
    end else begin
      qcnt_r  <= qcnt_nxt;
      acc_v_r <= acc_v_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r < (QW + 1)'(QD))
    else $error("head queue overrun");
`endif

endmodule

// ===== design/first_fit_heap_allocator_unit.sv =====
`timescale 1ns / 1ps

// first-fit heap allocator over a table of MAX_BLOCKS rows held in a ring of cells
//
// channels: input beats carry an op (init, allocate, release), a request size and a
// release address; every input beat gives exactly one output beat with the payload
// address, a status code and the free byte count. cfg_write_en with cfg_index and
// cfg_data sets heap base and heap length; write them only while the unit is idle.
// sequence: an accepted beat runs through the setup states PREP1, PREP2 and PREP3 (rounding
// and checks), then a full rotation of the row ring through the head cell, then the hold
// state that posts the result to the output register.
// one beat at a time: a new beat is not taken until the previous one has left the hold
// state; every row passes the head cell once per beat.
// in_stall is high while a beat is in work; a new beat is taken while the previous
// result still waits in the output register.
// reset: heap is not set up, config registers are zero, no output beat pending.
// out_stall: the result is held steady; a finished beat waits until the output
// register is free before the unit goes idle again.
module first_fit_heap_allocator_unit #(
  parameter int unsigned ALIGN_BYTES  = 8,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [23:0] in_request_bytes,
  input  logic [31:0] in_release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_payload_address,
  output logic [2:0]  out_status,
  output logic [23:0] out_free_bytes,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned AL    = $clog2(ALIGN_BYTES);
  localparam int unsigned PW    = AL + 1;
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned STEPS = MAX_BLOCKS + ffha_pkg::LAG;
  localparam int unsigned SW    = $clog2(STEPS);
  // reciprocal constants for exact division by ALIGN_BYTES
  localparam int unsigned SH_B  = 32 + AL;
  localparam int unsigned SH_R  = 24 + AL;
  localparam logic [71:0] M_B   = ((72'd1 << SH_B) + 72'(ALIGN_BYTES) - 72'd1) / 72'(ALIGN_BYTES);
  localparam logic [71:0] M_R   = ((72'd1 << SH_R) + 72'(ALIGN_BYTES) - 72'd1) / 72'(ALIGN_BYTES);

  ffha_pkg::ffha_state_t state_r, state_nxt;

  // configuration
  logic [31:0] heap_base_r;
  logic [23:0] heap_length_r;

  // accepted beat
  logic [1:0]  op_r;
  logic [23:0] req_r;
  logic [31:0] rel_r;

  // heap state
  logic [CW-1:0] block_count_r;
  logic [31:0]   aligned_base_r;
  logic [23:0]   free_total_r;

  // setup pipeline
  logic [31:0]   q_base_r;
  logic [23:0]   q_req_r;
  logic [32:0]   al_r;
  logic [PW-1:0] pad_r;
  logic [24:0]   need_r;
  logic          heap_up_r;
  ffha_pkg::ffha_ctl_t ctl_r;

  // pass bookkeeping
  logic [SW-1:0] step_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [23:0]   sum_r, sum_nxt;

  // pending result and output register
  logic [31:0] res_addr_r;
  logic [2:0]  res_status_r;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [2:0]  out_status_r;
  logic [23:0] out_free_r;

  // ring and head
  ffha_pkg::ffha_entry_t ring_q [MAX_BLOCKS];
  ffha_pkg::ffha_entry_t tail_entry;
  logic                  emit_v;
  ffha_pkg::ffha_hres_t  head_res;
  logic                  run, last_step, out_free, accept;

  // setup arithmetic
  logic [71:0]   prod_b, prod_r;
  logic [31:0]   rem_b;
  logic [23:0]   rem_r;
  logic [PW-1:0] pad_b, pad_q;
  logic [24:0]   need_b;
  logic          init_ok;
  logic [23:0]   hdr24;
  logic [2:0]    status_fin;

  assign accept    = in_valid && !in_stall;
  assign run       = (state_r == ffha_pkg::ST_RUN);
  assign last_step = (step_r == SW'(STEPS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ffha_pkg::ST_IDLE);
  assign hdr24     = 24'(HDR);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      heap_length_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        ffha_pkg::REG_HEAP_BASE:   heap_base_r   <= cfg_data;
        ffha_pkg::REG_HEAP_LENGTH: heap_length_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // quotients by reciprocal multiply, then remainders, then round up
  assign prod_b = 72'(heap_base_r) * M_B;
  assign prod_r = 72'(in_request_bytes) * M_R;
  assign rem_b  = heap_base_r - 32'(64'(q_base_r) * 64'(ALIGN_BYTES));
  assign rem_r  = req_r - 24'(48'(q_req_r) * 48'(ALIGN_BYTES));
  assign pad_b  = (rem_b == '0) ? '0 : PW'(ALIGN_BYTES - 32'(rem_b[PW-1:0]));
  assign pad_q  = (rem_r == '0) ? '0 : PW'(ALIGN_BYTES - 32'(rem_r[PW-1:0]));
  assign need_b = 25'(req_r) + 25'(pad_q);
  assign init_ok = (heap_base_r != '0) && (heap_length_r > hdr24) && !al_r[32] &&
                   (24'(pad_r) < heap_length_r) &&
                   ((heap_length_r - 24'(pad_r)) > hdr24);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::ST_IDLE:  if (accept) state_nxt = ffha_pkg::ST_PREP1;
      ffha_pkg::ST_PREP1: state_nxt = ffha_pkg::ST_PREP2;
      ffha_pkg::ST_PREP2: state_nxt = ffha_pkg::ST_PREP3;
      ffha_pkg::ST_PREP3: state_nxt = ffha_pkg::ST_RUN;
      ffha_pkg::ST_RUN:   if (last_step) state_nxt = ffha_pkg::ST_HOLD;
      ffha_pkg::ST_HOLD:  if (out_free) state_nxt = ffha_pkg::ST_IDLE;
      default:            state_nxt = ffha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // beat capture and setup stages
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      req_r   <= in_request_bytes;
      rel_r   <= in_release_address;
      q_req_r <= 24'(prod_r >> SH_R);
    end
    if (state_r == ffha_pkg::ST_PREP1) begin
      q_base_r <= 32'(prod_b >> SH_B);
    end
    if (state_r == ffha_pkg::ST_PREP2) begin
      al_r   <= 33'(heap_base_r) + 33'(pad_b);
      pad_r  <= pad_b;
      need_r <= need_b;
    end
    if (state_r == ffha_pkg::ST_PREP3) begin
      heap_up_r            <= (block_count_r != '0);
      ctl_r.alloc_en       <= (op_r == ffha_pkg::OP_ALLOC) && (block_count_r != '0) &&
                              (need_r != '0);
      ctl_r.release_en     <= (op_r == ffha_pkg::OP_RELEASE) && (rel_r != '0) &&
                              (block_count_r != '0);
      ctl_r.init_en        <= (op_r == ffha_pkg::OP_INIT) && init_ok;
      ctl_r.can_split      <= (block_count_r < CW'(MAX_BLOCKS));
      ctl_r.need           <= need_r;
      ctl_r.need_hdr       <= 26'(need_r) + 26'(HDR);
      ctl_r.need_split     <= 27'(need_r) + 27'(HDR) + 27'(ALIGN_BYTES);
      ctl_r.base_hdr       <= aligned_base_r + 32'(HDR);
      ctl_r.want           <= rel_r - aligned_base_r - 32'(HDR);
      ctl_r.init_size      <= heap_length_r - 24'(pad_r) - hdr24;
    end
  end

  // rotation of the row ring; the head writes the rebuilt table at the tail
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_ring
    if (g == MAX_BLOCKS - 1) begin : g_tail
      ffha_cell u_cell (.clk(clk), .shift(run), .d(tail_entry), .q(ring_q[g]));
    end else begin : g_mid
      ffha_cell u_cell (.clk(clk), .shift(run), .d(ring_q[g + 1]), .q(ring_q[g]));
    end
  end

  // an init drops the old rows, whether or not the new heap is valid
  ffha_head #(.HDR_BYTES(HDR)) u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (state_r == ffha_pkg::ST_PREP3),
    .step     (run),
    .first    (step_r == '0),
    .in_v     ((step_r < SW'(block_count_r)) && (op_r != ffha_pkg::OP_INIT)),
    .emit_en  (run && (step_r >= SW'(ffha_pkg::LAG))),
    .in_entry (ring_q[0]),
    .ctl      (ctl_r),
    .out_v    (emit_v),
    .out_entry(tail_entry),
    .res      (head_res)
  );

  // count and free-byte sum of the rows written back
  assign cnt_nxt = cnt_r + CW'(emit_v);
  assign sum_nxt = (emit_v && tail_entry.is_free) ? sum_r + tail_entry.size : sum_r;

  always_comb begin
    status_fin = ffha_pkg::STS_OK;
    unique case (op_r)
      ffha_pkg::OP_INIT: begin
        status_fin = ctl_r.init_en ? ffha_pkg::STS_OK : ffha_pkg::STS_NO_HEAP;
      end
      ffha_pkg::OP_ALLOC: begin
        priority if (!heap_up_r)     status_fin = ffha_pkg::STS_NO_HEAP;
        else if (need_r == '0)       status_fin = ffha_pkg::STS_NO_FIT;
        else if (!head_res.found)    status_fin = ffha_pkg::STS_NO_FIT;
        else if (head_res.full)      status_fin = ffha_pkg::STS_TABLE_FULL;
        else                         status_fin = ffha_pkg::STS_OK;
      end
      ffha_pkg::OP_RELEASE: begin
        priority if (rel_r == '0)    status_fin = ffha_pkg::STS_NULL;
        else if (!heap_up_r)         status_fin = ffha_pkg::STS_NO_HEAP;
        else if (head_res.found)     status_fin = ffha_pkg::STS_OK;
        else                         status_fin = ffha_pkg::STS_NOT_FOUND;
      end
      default: status_fin = ffha_pkg::STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= '0;
      cnt_r          <= '0;
      sum_r          <= '0;
      block_count_r  <= '0;
      aligned_base_r <= '0;
      free_total_r   <= '0;
    end else begin
      if (state_r == ffha_pkg::ST_PREP3) begin
        step_r <= '0;
        cnt_r  <= '0;
        sum_r  <= '0;
        if (op_r == ffha_pkg::OP_INIT) begin
          aligned_base_r <= init_ok ? al_r[31:0] : '0;
        end
      end else if (run) begin
        step_r <= step_r + 1'b1;
        cnt_r  <= cnt_nxt;
        sum_r  <= sum_nxt;
        if (last_step) begin
          block_count_r <= cnt_nxt;
          free_total_r  <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run && last_step) begin
      res_status_r <= status_fin;
      res_addr_r   <= (ctl_r.alloc_en && head_res.found) ? head_res.addr : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ffha_pkg::ST_HOLD) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ffha_pkg::ST_HOLD) && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_free_r   <= free_total_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;
  assign out_free_bytes      = out_free_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    block_count_r <= CW'(MAX_BLOCKS))
    else $error("block count above table size");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ffha_pkg::ST_HOLD))
    else $error("output beat without finished pass");

  a_writeback_lag: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (SW'(cnt_r) <= step_r))
    else $error("more rows written back than steps taken");
`endif

endmodule
